// ===== rtl/vprc_pkg.sv =====
package vprc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_REGION_START   = 3'd0,
    REG_ROW_WIDTH      = 3'd1,
    REG_ROW_STRIDE     = 3'd2,
    REG_REGION_END     = 3'd3,
    REG_FRAME_END_MASK = 3'd4
  } reg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 24;

  localparam logic [23:0] RegionStartRst  = 24'd0;
  localparam logic [15:0] RowWidthRst     = 16'd64;
  localparam logic [15:0] RowStrideRst    = 16'd1280;
  localparam logic [23:0] RegionEndRst    = 24'd65536;
  localparam logic [7:0]  FrameEndMaskRst = 8'd2;

  // Header byte index that carries the frame-end flags
  localparam logic [7:0] FlagByteIdx = 8'd1;
  localparam logic [7:0] ByteIdxMax  = 8'd255;

  // Result queue between front and back
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QCountW = 3;

  typedef struct packed {
    logic [23:0] region_start;
    logic [15:0] row_width;
    logic [15:0] row_stride;
    logic [23:0] region_end;
    logic [7:0]  frame_end_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] window_byte;
    logic       row_done;
  } result_t;

endpackage

// ===== rtl/video_packet_roi_crop_top.sv =====
// A result is written into the queue when its byte is accepted and can be popped in the next cycle.
// Throughput: one item per cycle while the queue is not full; the front section updates its frame state once per item.
// A four-entry result queue lets the front keep taking items while results wait for pop.
// full asserts only while that queue holds four results.
// Reset (rst_ni low, asynchronous) empties the queue, loads register defaults, sets idle mode.
module video_packet_roi_crop_top #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         data_byte_i,
  input  logic                               packet_first_i,
  input  logic                               packet_last_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [7:0]                         window_byte_o,
  output logic                               row_done_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vprc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [vprc_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import vprc_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  logic    res_valid;
  result_t res, head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_start   <= RegionStartRst;
      cfg_q.row_width      <= RowWidthRst;
      cfg_q.row_stride     <= RowStrideRst;
      cfg_q.region_end     <= RegionEndRst;
      cfg_q.frame_end_mask <= FrameEndMaskRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REGION_START:   cfg_q.region_start   <= cfg_data_i;
        REG_ROW_WIDTH:      cfg_q.row_width      <= cfg_data_i[15:0];
        REG_ROW_STRIDE:     cfg_q.row_stride     <= cfg_data_i[15:0];
        REG_REGION_END:     cfg_q.region_end     <= cfg_data_i;
        REG_FRAME_END_MASK: cfg_q.frame_end_mask <= cfg_data_i[7:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  vprc_front #(
    .PositionWidth(POSITION_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .packet_first_i(packet_first_i),
    .packet_last_i (packet_last_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  vprc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (res_valid),
    .wr_data_i(res),
    .rd_i     (pop),
    .rd_data_o(head),
    .full_o   (full),
    .empty_o  (empty)
  );

  assign window_byte_o = head.window_byte;
  assign row_done_o    = head.row_done;

endmodule

// ===== rtl/vprc_front.sv =====
module vprc_front #(
  parameter int unsigned PositionWidth = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vprc_pkg::cfg_t  cfg_i,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            packet_first_i,
  input  logic            packet_last_i,
  output logic            res_valid_o,
  output vprc_pkg::result_t res_o
);
  import vprc_pkg::*;

  localparam int unsigned PW   = PositionWidth;
  localparam int unsigned CmpW = (PositionWidth > 24) ? PositionWidth : 24;
  localparam logic [PW-1:0] PosMax = {PW{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_WAIT    = 2'd2
  } mode_e;

  mode_e         mode_q, mode_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] nrs_q, nrs_d;
  logic [7:0]    bip_q, bip_d;
  logic [7:0]    hlen_q, hlen_d;
  logic          fes_q, fes_d;

  logic [7:0]    idx;
  logic          is_payload;
  logic [PW:0]   row_end;
  logic [PW:0]   pos_p1;
  logic [PW:0]   nrs_sum;
  logic [PW-1:0] nrs_adv;
  logic [PW-1:0] pos_inc;
  logic [CmpW-1:0] rs_ext;
  logic [PW-1:0] rs_sat;
  logic          in_win;
  logic          done;

  always_comb begin
    idx     = packet_first_i ? 8'd0 : bip_q;
    row_end = {1'b0, nrs_q} + (PW+1)'(cfg_i.row_width);
    pos_p1  = {1'b0, pos_q} + 1'b1;
    nrs_sum = {1'b0, nrs_q} + (PW+1)'(cfg_i.row_stride);
    nrs_adv = nrs_sum[PW] ? PosMax : nrs_sum[PW-1:0];
    pos_inc = (pos_q == PosMax) ? pos_q : pos_p1[PW-1:0];
    rs_ext  = CmpW'(cfg_i.region_start);
    rs_sat  = (rs_ext > CmpW'(PosMax)) ? PosMax : rs_ext[PW-1:0];
    in_win  = (CmpW'(pos_q) < CmpW'(cfg_i.region_end)) && (pos_q >= nrs_q) &&
              ({1'b0, pos_q} < row_end);
    done    = (pos_p1 == row_end);

    mode_d = mode_q;
    pos_d  = pos_q;
    nrs_d  = nrs_q;
    bip_d  = bip_q;
    hlen_d = (idx == 8'd0) ? data_byte_i : hlen_q;
    fes_d  = fes_q;
    if (idx == 8'd0) begin
      fes_d = 1'b0;
    end else if (idx == FlagByteIdx) begin
      fes_d = (data_byte_i & cfg_i.frame_end_mask) == cfg_i.frame_end_mask;
    end

    is_payload = (mode_q == MODE_COLLECT) && (idx >= hlen_d);
    res_valid_o = accept_i && is_payload && in_win;
    res_o.window_byte = data_byte_i;
    res_o.row_done    = done;

    if (is_payload) begin
      pos_d = pos_inc;
      if (in_win && done) begin
        nrs_d = nrs_adv;
      end
    end

    if (packet_last_i) begin
      if (mode_q == MODE_COLLECT) begin
        // past the region: park until the next frame end
        if (CmpW'(pos_d) >= CmpW'(cfg_i.region_end)) begin
          mode_d = MODE_WAIT;
          pos_d  = '0;
          nrs_d  = rs_sat;
        end
      end else if (fes_d) begin
        mode_d = MODE_COLLECT;
        pos_d  = '0;
        nrs_d  = rs_sat;
      end
      bip_d = 8'd0;
    end else begin
      bip_d = (idx < ByteIdxMax) ? idx + 8'd1 : ByteIdxMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      nrs_q  <= '0;
      bip_q  <= 8'd0;
      hlen_q <= 8'd0;
      fes_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      nrs_q  <= nrs_d;
      bip_q  <= bip_d;
      hlen_q <= hlen_d;
      fes_q  <= fes_d;
    end
  end

endmodule

// ===== rtl/vprc_queue.sv =====
module vprc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  vprc_pkg::result_t wr_data_i,
  input  logic              rd_i,
  output vprc_pkg::result_t rd_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import vprc_pkg::*;

  result_t             mem_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCountW-1:0]  count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == QCountW'(QDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== test/video_packet_roi_crop_top_tb.sv =====
module video_packet_roi_crop_top_tb;
  import vprc_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DrainLimit    = 20000;
  localparam int unsigned HoldCycles    = 300;
  localparam logic [31:0] PosMax        = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    CropIdle    = 2'd0,
    CropCollect = 2'd1,
    CropWait    = 2'd2
  } crop_mode_e;

  class roi_scoreboard;
    cfg_t        regs;
    crop_mode_e  mode;
    logic [31:0] position;
    logic [31:0] row_start;
    logic [7:0]  byte_cnt;
    logic [7:0]  hdr_len;
    logic        frame_end;
    result_t     window_q[$];
    int          mismatches;

    function new();
      regs.region_start   = RegionStartRst;
      regs.row_width      = RowWidthRst;
      regs.row_stride     = RowStrideRst;
      regs.region_end     = RegionEndRst;
      regs.frame_end_mask = FrameEndMaskRst;
      mode       = CropIdle;
      position   = '0;
      row_start  = '0;
      byte_cnt   = '0;
      hdr_len    = '0;
      frame_end  = 1'b0;
      mismatches = 0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, what);
    endfunction

    function void write_reg(reg_idx_e idx, logic [23:0] val);
      case (idx)
        REG_REGION_START:   regs.region_start   = val;
        REG_ROW_WIDTH:      regs.row_width      = val[15:0];
        REG_ROW_STRIDE:     regs.row_stride     = val[15:0];
        REG_REGION_END:     regs.region_end     = val;
        REG_FRAME_END_MASK: regs.frame_end_mask = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp_pos(logic [31:0] v);
      return (v > PosMax) ? PosMax : v;
    endfunction

    // Advance the crop state by one accepted byte and queue the window byte it yields.
    function void note_byte(logic [7:0] data, logic first, logic last);
      logic [7:0]  idx;
      logic [31:0] row_end;
      result_t     res;
      idx = first ? 8'd0 : byte_cnt;
      if (idx == 8'd0) begin
        hdr_len   = data;
        frame_end = 1'b0;
      end
      if (idx == FlagByteIdx) begin
        frame_end = (data & regs.frame_end_mask) == regs.frame_end_mask;
      end
      if (mode == CropCollect && idx >= hdr_len) begin
        row_end = row_start + regs.row_width;
        if (position < regs.region_end && position >= row_start && position < row_end) begin
          res.window_byte = data;
          res.row_done    = (position + 1) == row_end;
          window_q.push_back(res);
          if (res.row_done) row_start = clamp_pos(row_start + regs.row_stride);
        end
        position = clamp_pos(position + 1);
      end
      if (last) begin
        if (mode == CropCollect) begin
          if (position >= regs.region_end) begin
            mode      = CropWait;
            position  = '0;
            row_start = regs.region_start;
          end
        end else if (frame_end) begin
          mode      = CropCollect;
          position  = '0;
          row_start = regs.region_start;
        end
        byte_cnt = '0;
      end else begin
        byte_cnt = (idx < ByteIdxMax) ? idx + 8'd1 : ByteIdxMax;
      end
    endfunction

    function void check_result(logic [7:0] win, logic done);
      result_t want;
      if (window_q.size() == 0) begin
        flag($sformatf("unexpected byte %h row_done %b", win, done));
        return;
      end
      want = window_q.pop_front();
      if (win !== want.window_byte || done !== want.row_done) begin
        flag($sformatf("expected byte %h row_done %b, got byte %h row_done %b",
                       want.window_byte, want.row_done, win, done));
      end
    endfunction

    function int pending();
      return window_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  logic [7:0]              data_byte;
  logic                    packet_first;
  logic                    packet_last;
  logic                    empty;
  logic                    pop;
  logic [7:0]              window_byte;
  logic                    row_done;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  bit            no_idle;
  bit            hold_req;
  int            hold_left;
  int            items_sent;
  roi_scoreboard sb = new();

  video_packet_roi_crop_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte),
    .packet_first_i (packet_first),
    .packet_last_i  (packet_last),
    .empty          (empty),
    .pop            (pop),
    .window_byte_o  (window_byte),
    .row_done_o     (row_done),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    data_byte    <= data;
    packet_first <= first;
    packet_last  <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(data, first, last);
    items_sent++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [23:0] start_pos, input logic [15:0] width,
                           input logic [15:0] stride, input logic [23:0] end_pos,
                           input logic [7:0] mask);
    write_reg(REG_REGION_START, start_pos);
    write_reg(REG_ROW_WIDTH, {8'd0, width});
    write_reg(REG_ROW_STRIDE, {8'd0, stride});
    write_reg(REG_REGION_END, end_pos);
    write_reg(REG_FRAME_END_MASK, {16'd0, mask});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every window byte, then let the front section settle.
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic rand_packet(input logic [7:0] mask, input bit force_long);
    int         len;
    int         k;
    int         roll;
    bit         cut;
    bit         skip_first;
    bit         noise;
    logic [7:0] hdr;
    logic [7:0] flags;
    logic [7:0] data;
    logic       first;
    logic       last;
    noise      = $urandom_range(99) < 5;
    cut        = $urandom_range(99) < 8;
    skip_first = $urandom_range(99) < 5;
    roll       = $urandom_range(99);
    if (force_long) len = $urandom_range(260, 300);
    else if (roll < 5) len = 1;
    else if (roll < 6) len = $urandom_range(256, 300);
    else len = $urandom_range(2, 40);
    hdr   = 8'(($urandom_range(99) < 70) ? $urandom_range(4) : $urandom_range(255));
    flags = 8'($urandom_range(1) ? ($urandom_range(255) | 32'(mask)) : $urandom_range(255));
    for (k = 0; k < len; k++) begin
      data = (k == 0) ? hdr : (k == 1) ? flags : 8'($urandom_range(255));
      if (noise) begin
        first = $urandom_range(4) == 0;
        last  = $urandom_range(4) == 0;
      end else begin
        first = (k == 0) && !skip_first;
        last  = (k == len - 1) && !cut;
      end
      send_byte(data, first, last);
    end
  endtask

  task automatic run_random(input int n_items, input logic [7:0] mask, input bit with_long);
    int start_cnt;
    start_cnt = items_sent;
    if (with_long) rand_packet(mask, 1'b1);
    while (items_sent - start_cnt < n_items) rand_packet(mask, 1'b0);
    drain();
  endtask

  task automatic directed_items();
    configure(24'd2, 16'd3, 16'd5, 24'd24, 8'h06);
    // frame end marker, collection starts with the next packet
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'h06, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // zero header length: header bytes are payload
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    // one-byte packet
    send_byte(8'h00, 1'b1, 1'b1);
    // header length one, started only by the previous last flag
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    // packet cut short by a new first flag
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    // header longer than the packet
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h06, 1'b0, 1'b0);
    send_byte(8'hEE, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 1'b1);
    drain();
  endtask

  initial begin
    repeat (TimeoutCycles) @(posedge clk);
    $display("FAIL video_packet_roi_crop_top");
    $finish;
  end

  // Result side: random pop, plus one long hold-off on request.
  initial begin
    pop       = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 35);
      end
      @(posedge clk);
      if (pop && !empty) sb.check_result(window_byte, row_done);
    end
  end

  initial begin
    logic [7:0] mask_r;
    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte    = '0;
    packet_first = 1'b0;
    packet_last  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_REGION_START;
    cfg_data     = '0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    items_sent   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset register values first
    run_random(50, FrameEndMaskRst, 1'b0);
    directed_items();

    // take every payload byte and stall the result side until the block backs up
    configure(24'd0, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'h00);
    hold_req = 1'b1;
    run_random(80, 8'h00, 1'b0);

    configure(24'd0, 16'd1, 16'd1, 24'd300, 8'hFF);
    run_random(100, 8'hFF, 1'b1);

    // overlapping rows, both sides busy every cycle
    no_idle = 1'b1;
    configure(24'd5, 16'd9, 16'd3, 24'd150, 8'h02);
    run_random(50, 8'h02, 1'b0);
    no_idle = 1'b0;

    configure(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'h80);
    run_random(30, 8'h80, 1'b0);

    configure(24'd0, 16'd4, 16'd4, 24'd0, 8'h01);
    run_random(30, 8'h01, 1'b0);

    mask_r = 8'($urandom_range(255));
    configure(24'($urandom_range(24'hFF_FFFF)), 16'($urandom_range(1, 16'hFFFF)),
              16'($urandom_range(1, 16'hFFFF)), 24'($urandom_range(24'hFF_FFFF)), mask_r);
    run_random(30, mask_r, 1'b0);

    repeat (4) begin
      mask_r = 8'($urandom_range(255) & $urandom_range(255));
      configure(24'($urandom_range(24)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 20)), 24'($urandom_range(400)), mask_r);
      run_random(40, mask_r, 1'b0);
    end

    if (sb.pending() != 0) sb.flag($sformatf("%0d window bytes never came", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("PASS video_packet_roi_crop_top");
    end else begin
      $display("FAIL video_packet_roi_crop_top");
    end
    $finish;
  end

endmodule
